// ----- rtl/aes128_pkg.sv -----
// Shared types, constants and byte functions for the AES-128 encryption block.
// Used by aes128_round and aes128_block_encrypt; depends on nothing else.
`default_nettype none

package aes128_pkg;

  // Input word: one 128-bit plaintext block, byte 0 in the top bits.
  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } aes128_in_t;

  // Result word: one 128-bit ciphertext block, byte 0 in the top bits.
  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } aes128_out_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

  // Key register values after reset.
  localparam logic [31:0] KEY_WORD0_RESET = 32'h5468_6174;
  localparam logic [31:0] KEY_WORD1_RESET = 32'h7320_6D79;
  localparam logic [31:0] KEY_WORD2_RESET = 32'h204B_756E;
  localparam logic [31:0] KEY_WORD3_RESET = 32'h6720_4675;

  // Round counting: ten rounds, the first round constant and the field polynomial.
  localparam int unsigned NUM_ROUNDS   = 10;
  localparam logic [3:0]  FIRST_ROUND  = 4'd1;
  localparam logic [3:0]  LAST_ROUND   = 4'(NUM_ROUNDS);
  localparam logic [7:0]  RCON_FIRST   = 8'h01;
  localparam logic [7:0]  GF_REDUCE    = 8'h1b;

  // Forward substitution table.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte substitution.
  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    return SBOX[a];
  endfunction

  // Multiplication by two in GF(2^8).
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

endpackage : aes128_pkg

`default_nettype wire

// ----- rtl/aes128_round.sv -----
// One AES-128 round and one round-key expansion step, purely combinational.
// Depends on aes128_pkg for the substitution table and GF doubling.
`default_nettype none

module aes128_round (
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] rkey_in,
  input  wire logic [7:0]   rcon,
  input  wire logic         final_round,
  output logic      [127:0] state_out,
  output logic      [127:0] rkey_out
);
  import aes128_pkg::*;

  logic [7:0]   s_byte  [16];
  logic [7:0]   ss_byte [16];
  logic [7:0]   mc_byte [16];
  logic [127:0] mixed;
  logic [127:0] shifted;
  logic [31:0]  w0, w1, w2, w3, tw;
  logic [31:0]  n0, n1, n2, n3;

  // Split the state into bytes, byte 0 in the top bits.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s_byte[k] = state_in[127 - 8*k -: 8];
    end
  end

  // SubBytes and ShiftRows: byte (column c, row r) comes from column c+r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss_byte[c*4 + r] = sub_byte(s_byte[((c + r) % 4)*4 + r]);
      end
    end
  end

  // MixColumns over each column independently.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = ss_byte[4*c] ^ ss_byte[4*c+1] ^ ss_byte[4*c+2] ^ ss_byte[4*c+3];
      mc_byte[4*c]   = ss_byte[4*c]   ^ all ^ gf_double(ss_byte[4*c]   ^ ss_byte[4*c+1]);
      mc_byte[4*c+1] = ss_byte[4*c+1] ^ all ^ gf_double(ss_byte[4*c+1] ^ ss_byte[4*c+2]);
      mc_byte[4*c+2] = ss_byte[4*c+2] ^ all ^ gf_double(ss_byte[4*c+2] ^ ss_byte[4*c+3]);
      mc_byte[4*c+3] = ss_byte[4*c+3] ^ all ^ gf_double(ss_byte[4*c+3] ^ ss_byte[4*c]);
    end
  end

  // Pack both versions back into 128-bit words.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      shifted[127 - 8*k -: 8] = ss_byte[k];
      mixed[127 - 8*k -: 8]   = mc_byte[k];
    end
  end

  // Next round key: rotate, substitute and add the round constant to the last word.
  assign w0 = rkey_in[127:96];
  assign w1 = rkey_in[95:64];
  assign w2 = rkey_in[63:32];
  assign w3 = rkey_in[31:0];
  assign tw = {sub_byte(w3[23:16]) ^ rcon, sub_byte(w3[15:8]),
               sub_byte(w3[7:0]), sub_byte(w3[31:24])};
  assign n0 = w0 ^ tw;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;
  assign rkey_out = {n0, n1, n2, n3};

  // The final round leaves out MixColumns.
  assign state_out = (final_round ? shifted : mixed) ^ rkey_out;

endmodule : aes128_round

`default_nettype wire

// ----- rtl/aes128_block_encrypt.sv -----
// AES-128 block encryption: one round per cycle through a shared round unit.
// The result word is registered with the last round and strobed on done as busy falls.
// A new block is not taken while busy is high during the rounds,
// and a new start is taken in the cycle that done is high.
// Reset puts the key registers at their reset key and leaves the block idle.
// Depends on aes128_pkg and aes128_round.
`default_nettype none

module aes128_block_encrypt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [1:0]               wr_index,
  input  wire logic [31:0]              wr_data,
  input  wire logic                     start,
  input  wire aes128_pkg::aes128_in_t   plaintext,
  output logic                          busy,
  output logic                          done,
  output aes128_pkg::aes128_out_t       ciphertext
);
  import aes128_pkg::*;

  logic [31:0]  key_word0, key_word1, key_word2, key_word3;
  logic [127:0] block;
  logic [127:0] rkey;
  logic [7:0]   rcon;
  logic [3:0]   round_cnt;
  logic [127:0] cipher_key;
  logic [127:0] round_state;
  logic [127:0] round_key;
  logic         accept;
  logic         last_round;

  assign accept     = start && !busy;
  assign last_round = (round_cnt == LAST_ROUND);
  assign cipher_key = {key_word0, key_word1, key_word2, key_word3};

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= KEY_WORD0_RESET;
      key_word1 <= KEY_WORD1_RESET;
      key_word2 <= KEY_WORD2_RESET;
      key_word3 <= KEY_WORD3_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY_WORD0: key_word0 <= wr_data;
        REG_KEY_WORD1: key_word1 <= wr_data;
        REG_KEY_WORD2: key_word2 <= wr_data;
        REG_KEY_WORD3: key_word3 <= wr_data;
        default: ;
      endcase
    end
  end

  // The shared round unit.
  aes128_round u_round (
    .state_in    (block),
    .rkey_in     (rkey),
    .rcon        (rcon),
    .final_round (last_round),
    .state_out   (round_state),
    .rkey_out    (round_key)
  );

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      round_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy      <= 1'b1;
        round_cnt <= FIRST_ROUND;
      end else if (busy) begin
        if (last_round) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        round_cnt <= round_cnt + 4'd1;
      end
    end
  end

  // Data path: initial key addition at start, then one round per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      block <= {plaintext.plaintext_high, plaintext.plaintext_low} ^ cipher_key;
      rkey  <= cipher_key;
      rcon  <= RCON_FIRST;
    end else if (busy) begin
      block <= round_state;
      rkey  <= round_key;
      rcon  <= gf_double(rcon);
      if (last_round) begin
        ciphertext <= round_state;
      end
    end
  end

  // The result strobe never overlaps a block in flight.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while a block is still in flight");

  // A busy sequencer always sits on a valid round.
  assert property (@(posedge clk) disable iff (rst)
                   busy |-> (round_cnt >= FIRST_ROUND && round_cnt <= LAST_ROUND))
    else $error("round counter out of range while busy");

  // Starting a block always begins at the first round.
  assert property (@(posedge clk) disable iff (rst)
                   accept |=> (busy && round_cnt == FIRST_ROUND))
    else $error("block start did not enter the first round");

  // Every block that finishes produces exactly one result strobe.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy fell without a result strobe");

endmodule : aes128_block_encrypt

`default_nettype wire

// ----- dv/aes128_block_encrypt_tb.sv -----
// Self-checking testbench for aes128_block_encrypt: plaintext words are encrypted by an
// in-bench AES-128 predictor under a shadow copy of the key registers and compared on done.
// Depends on aes128_pkg and the RTL of aes128_block_encrypt.
`default_nettype none

module aes128_block_encrypt_tb;
  import aes128_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1834;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [1:0] KEY_REGS [4] = '{REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2,
                                          REG_KEY_WORD3};

  typedef enum logic {OP_BLOCK, OP_KEY_WRITE} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    aes128_in_t  pt;
    logic [1:0]  idx;
    logic [31:0] data;
    int unsigned gap;
  } pending_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_KEY_WORD0;
  logic [31:0] wr_data = '0;
  logic        start = 1'b0;
  aes128_in_t  plaintext = '0;
  logic        busy;
  logic        done;
  aes128_out_t ciphertext;

  pending_op_t pending_ops [$];
  aes128_out_t cipher_q [$];
  logic [31:0] key_words [4] = '{KEY_WORD0_RESET, KEY_WORD1_RESET, KEY_WORD2_RESET,
                                 KEY_WORD3_RESET};
  int unsigned gap_left = 0;
  int unsigned blocks_sent = 0;
  int unsigned blocks_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  logic        stim_done = 1'b0;

  aes128_block_encrypt u_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .start      (start),
    .plaintext  (plaintext),
    .busy       (busy),
    .done       (done),
    .ciphertext (ciphertext)
  );

  initial forever #1 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Multiplication by x in GF(2^8).
  function automatic logic [7:0] times_x(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  // Full AES-128 encryption of one block, byte 0 in the top bits of both key and block.
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [7:0]   st [16];
    logic [7:0]   rk [16];
    logic [7:0]   sh [16];
    logic [7:0]   tw [4];
    logic [7:0]   rc;
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) begin
      rk[k] = key[127 - 8 * k -: 8];
      st[k] = blk[127 - 8 * k -: 8] ^ rk[k];
    end
    rc = RCON_FIRST;
    for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
      // Next round key: rotate, substitute and add the round constant.
      tw[0] = SBOX[rk[13]] ^ rc;
      tw[1] = SBOX[rk[14]];
      tw[2] = SBOX[rk[15]];
      tw[3] = SBOX[rk[12]];
      for (int k = 0; k < 4; k++) rk[k] = rk[k] ^ tw[k];
      for (int k = 4; k < 16; k++) rk[k] = rk[k] ^ rk[k - 4];
      rc = times_x(rc);
      // SubBytes and ShiftRows together; columns are groups of four bytes.
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) sh[c * 4 + r] = SBOX[st[((c + r) % 4) * 4 + r]];
      end
      // MixColumns is skipped in the last round.
      if (rnd < NUM_ROUNDS) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4 * c];
          a1 = sh[4 * c + 1];
          a2 = sh[4 * c + 2];
          a3 = sh[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          sh[4 * c]     = a0 ^ all ^ times_x(a0 ^ a1);
          sh[4 * c + 1] = a1 ^ all ^ times_x(a1 ^ a2);
          sh[4 * c + 2] = a2 ^ all ^ times_x(a2 ^ a3);
          sh[4 * c + 3] = a3 ^ all ^ times_x(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] = sh[k] ^ rk[k];
    end
    for (int k = 0; k < 16; k++) res[127 - 8 * k -: 8] = st[k];
    return res;
  endfunction

  // Idle length before a word: mostly none or short, now and then long.
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(16, 60);
  endfunction

  // Plaintext of mixed shapes: dense random, pixel form, single bit or its complement and repeated byte.
  function automatic logic [127:0] pick_block();
    int unsigned r;
    logic [127:0] b;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      b = {$urandom, $urandom, $urandom, $urandom};
    end else if (r < 75) begin
      b = {8'($urandom), 120'd0};
    end else if (r < 85) begin
      b = 128'd1 << $urandom_range(0, 127);
      if ($urandom_range(0, 1) == 1) b = ~b;
    end else begin
      b = {16{8'($urandom)}};
    end
    return b;
  endfunction

  // Key word of mixed shapes, the extremes among them.
  function automatic logic [31:0] pick_key_word();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic add_block(input logic [127:0] b, input int unsigned gap);
    pending_op_t op;
    op.kind = OP_BLOCK;
    op.pt = b;
    op.idx = REG_KEY_WORD0;
    op.data = '0;
    op.gap = gap;
    pending_ops.push_back(op);
  endtask

  task automatic add_key_write(input logic [1:0] idx, input logic [31:0] data);
    pending_op_t op;
    op.kind = OP_KEY_WRITE;
    op.pt = '0;
    op.idx = idx;
    op.data = data;
    op.gap = idle_len(1'b0);
    pending_ops.push_back(op);
  endtask

  task automatic add_full_key(input logic [127:0] key);
    for (int k = 0; k < 4; k++) add_key_write(KEY_REGS[k], key[127 - 32 * k -: 32]);
  endtask

  // Stimulus: a directed opening, then random phases separated by key changes.
  initial begin : stimulus
    int unsigned   random_count;
    int unsigned   phase_len;
    bit            quiet;
    bit            wrote;
    logic [127:0] fips_key;
    logic [127:0] fips_pt;
    random_count = 0;
    fips_key = 128'h000102030405060708090a0b0c0d0e0f;
    fips_pt  = 128'h00112233445566778899aabbccddeeff;

    // The predictor itself must reproduce the published test vector.
    if (aes_encrypt(fips_key, fips_pt) != 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
      $error("predictor fails the known-answer vector");
      fail_count++;
    end

    // Reset key, field extremes and pixel-form blocks, mostly back to back.
    add_block('0, 0);
    add_block('1, 0);
    add_block({1'b1, 127'd0}, 0);
    add_block(128'd1, 0);
    add_block({32{4'h5}}, 0);
    add_block({32{4'ha}}, 3);
    add_block({8'h41, 120'd0}, 0);
    add_block({8'hff, 120'd0}, 0);
    add_block({8'h01, 120'd0}, 7);

    // All-zero and all-one keys.
    add_full_key('0);
    add_block('0, 0);
    add_block('1, 0);
    add_block(fips_pt, 0);
    add_full_key('1);
    add_block('0, 0);
    add_block('1, 0);

    // Published key, then a change of one key word only.
    add_full_key(fips_key);
    add_block(fips_pt, 0);
    add_block('0, 2);
    add_key_write(REG_KEY_WORD3, 32'h8000_0001);
    add_block(fips_pt, 0);

    // Random phases; some run with no idling at all.
    while (random_count < RANDOM_ITEMS) begin
      wrote = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1) == 1 || (k == 3 && !wrote)) begin
          add_key_write(KEY_REGS[k], pick_key_word());
          wrote = 1'b1;
        end
      end
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 120);
      for (int n = 0; n < phase_len; n++) add_block(pick_block(), idle_len(quiet));
      random_count += phase_len;
    end
  end

  // Driver: presents blocks and key writes from the pending list, with idle gaps.
  always @(posedge clk) begin : driver
    logic        taken;
    logic        go;
    logic        wr;
    pending_op_t op;
    if (rst) begin
      start <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      taken = start && !busy;
      go = start && !taken;
      wr = 1'b0;
      if (taken) begin
        cipher_q.push_back(aes_encrypt({key_words[REG_KEY_WORD0], key_words[REG_KEY_WORD1],
                                        key_words[REG_KEY_WORD2], key_words[REG_KEY_WORD3]},
                                       plaintext));
        blocks_sent <= blocks_sent + 1;
      end
      if (!go) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops[0];
          if (op.kind == OP_BLOCK) begin
            go = 1'b1;
            plaintext <= op.pt;
          end else if (!taken && blocks_sent == blocks_seen) begin
            // Key writes only land while nothing is in flight.
            wr = 1'b1;
            wr_index <= op.idx;
            wr_data <= op.data;
            key_words[op.idx] = op.data;
          end
          if (go || wr) begin
            void'(pending_ops.pop_front());
            gap_left = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
          end
        end
      end
      // Idle inputs carry noise that the block must ignore.
      if (!go) plaintext <= {$urandom, $urandom, $urandom, $urandom};
      if (!wr) begin
        wr_index <= 2'($urandom);
        wr_data <= $urandom;
      end
      start <= go;
      wr_en <= wr;
      stim_done <= !go && !wr && pending_ops.size() == 0;
    end
  end

  // Monitor: each strobed result word is checked against the oldest expected ciphertext.
  always @(posedge clk) begin : monitor
    aes128_out_t want;
    if (!rst && done) begin
      blocks_seen <= blocks_seen + 1;
      if (cipher_q.size() == 0) begin
        $error("result word with no block outstanding: %h", ciphertext);
        fail_count++;
      end else begin
        want = cipher_q.pop_front();
        if (ciphertext.ciphertext_high !== want.ciphertext_high) begin
          $error("ciphertext_high mismatch: expected %h, got %h",
                 want.ciphertext_high, ciphertext.ciphertext_high);
          fail_count++;
        end
        if (ciphertext.ciphertext_low !== want.ciphertext_low) begin
          $error("ciphertext_low mismatch: expected %h, got %h",
                 want.ciphertext_low, ciphertext.ciphertext_low);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // End of run: drain, allow the latency to pass, then report.
  initial begin : finish_ctl
    do @(posedge clk); while (!(stim_done && blocks_sent == blocks_seen));
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (cipher_q.size() != 0) begin
      $error("%0d expected ciphertexts never arrived", cipher_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : aes128_block_encrypt_tb

`default_nettype wire
